// ===== rtl/bsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, codes and helpers for the B-spline curve evaluator.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // default sizes
    localparam int MAX_DEGREE_DEF = 7;
    localparam int MAX_POINTS_DEF = 64;
    localparam int DIMENSION_DEF  = 3;

    // divider operand widths: numerator magnitude and divisor
    localparam int NUM_W     = 53;
    localparam int NUM_MAG_W = 52;
    localparam int DEN_W     = 33;

    // input operation codes
    localparam logic [1:0] OP_KNOT   = 2'd0;
    localparam logic [1:0] OP_POINT  = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef logic signed [31:0] t_q;
    typedef t_q [2:0] t_vec;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         slot;
        logic signed [31:0] param_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
        logic signed [31:0] slope_z;
        logic signed [31:0] bend_x;
        logic signed [31:0] bend_y;
        logic signed [31:0] bend_z;
        logic               bend_valid;
        logic               zero_span;
    } t_out;

    typedef enum logic {
        MDU_DIV = 1'b0,
        MDU_MUL = 1'b1
    } t_mdu_op;

    // request into the shared multiply / divide unit
    typedef struct packed {
        logic                      start;
        t_mdu_op                   op;
        logic signed [NUM_W-1:0]   a;
        logic signed [DEN_W-1:0]   b;
    } t_mdu_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } t_mdu_rsp;

    // saturate to signed 32 bits
    function automatic t_q sat32(logic signed [63:0] x);
        t_q r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/bsp_mdu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_mdu
// Shared sequential unit: signed truncating divide, one quotient bit per
// cycle, or signed multiply in two 33x16 partial products.
// ----------------------------------------------------------------------------
module bsp_mdu
    import bsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mdu_req i_req,
    output t_mdu_rsp o_rsp
);

    localparam int CW = $clog2(NUM_MAG_W);

    logic                    r_busy;
    t_mdu_op                 r_op;
    logic                    r_neg;
    logic [CW-1:0]           r_cnt;
    logic [NUM_MAG_W-1:0]    r_num;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [NUM_MAG_W-1:0]    r_quo;
    logic [63:0]             r_acc;
    logic [32:0]             r_ma;
    logic [31:0]             r_mb;
    logic                    r_done;
    logic signed [63:0]      r_res;

    logic [NUM_W-1:0]        a_abs;
    logic [DEN_W-1:0]        b_abs;
    logic [DEN_W:0]          rem_sh;
    logic                    ge;
    logic [DEN_W-1:0]        rem_nx;
    logic [NUM_MAG_W-1:0]    quo_nx;
    logic [48:0]             part;
    logic [63:0]             acc_nx;
    logic                    last;
    logic [63:0]             mag;

    // operand magnitudes
    assign a_abs = i_req.a[NUM_W-1] ? NUM_W'(-i_req.a) : NUM_W'(i_req.a);
    assign b_abs = i_req.b[DEN_W-1] ? DEN_W'(-i_req.b) : DEN_W'(i_req.b);

    // restoring divide step
    assign rem_sh = {r_rem, r_num[NUM_MAG_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign rem_nx = ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
    assign quo_nx = {r_quo[NUM_MAG_W-2:0], ge};

    // multiply step, low half then high half
    assign part   = 49'(r_ma) * 49'(r_mb[15:0]);
    assign acc_nx = (r_cnt == '0) ? 64'(part) : r_acc + (64'(part) << 16);

    assign last = (r_op == MDU_DIV) ? (r_cnt == CW'(NUM_MAG_W - 1)) : (r_cnt == CW'(1));
    assign mag  = (r_op == MDU_DIV) ? 64'(quo_nx) : acc_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_op   <= i_req.op;
                    r_neg  <= i_req.a[NUM_W-1] ^ i_req.b[DEN_W-1];
                    r_cnt  <= '0;
                    r_num  <= a_abs[NUM_MAG_W-1:0];
                    r_den  <= b_abs;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_acc  <= '0;
                    r_ma   <= a_abs[32:0];
                    r_mb   <= b_abs[31:0];
                end
            end else begin
                r_cnt <= r_cnt + CW'(1);
                r_num <= {r_num[NUM_MAG_W-2:0], 1'b0};
                r_rem <= rem_nx;
                r_quo <= quo_nx;
                r_acc <= acc_nx;
                r_mb  <= {16'd0, r_mb[31:16]};
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= r_neg ? -$signed(mag) : $signed(mag);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// ===== rtl/bspline_de_boor_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator
// Knot and control point stores with a de Boor sequencer over one shared
// multiply / divide unit; gives point, slope and bend of a B-spline curve.
// ----------------------------------------------------------------------------
// Writes are taken while idle. An evaluation searches the knots, copies the
// control points, then runs p(p+1)/2 interpolations (a divide and three
// multiplies each) and the slope and bend terms, with 12 divides for p>=2.
// One item at a time.
// Reset sets degree 3, count 4 and clears control; the stores hold no value
// until written.
module bspline_de_boor_evaluator
    import bsp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int DIMENSION  = DIMENSION_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    localparam int KD  = MAX_POINTS + MAX_DEGREE - 1;
    localparam int KAW = $clog2(KD);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int WD  = MAX_DEGREE + 1;
    localparam int WAW = $clog2(WD);
    localparam int PW  = WAW;
    localparam int JW  = (PW > 2) ? PW : 2;
    localparam int IW0 = $clog2(MAX_POINTS + MAX_DEGREE + 2) + 1;
    localparam int IW  = (IW0 > 8) ? IW0 : 8;

    typedef enum logic [23:0] {
        ST_IDLE  = 24'h000001,
        ST_SRCH  = 24'h000002,
        ST_SRCHW = 24'h000004,
        ST_KF    = 24'h000008,
        ST_KFW   = 24'h000010,
        ST_CP    = 24'h000020,
        ST_CPW   = 24'h000040,
        ST_NEXT  = 24'h000080,
        ST_ILD   = 24'h000100,
        ST_ILD2  = 24'h000200,
        ST_ISPAN = 24'h000400,
        ST_IDIV  = 24'h000800,
        ST_IMUL  = 24'h001000,
        ST_IMULW = 24'h002000,
        ST_IWB   = 24'h004000,
        ST_BND   = 24'h008000,
        ST_BND2  = 24'h010000,
        ST_BND3  = 24'h020000,
        ST_SLP   = 24'h040000,
        ST_SLP2  = 24'h080000,
        ST_SC    = 24'h100000,
        ST_SCW   = 24'h200000,
        ST_FIN   = 24'h400000,
        ST_OUT   = 24'h800000
    } t_state;

    // which scaled difference is in flight
    typedef enum logic [1:0] {
        SEL_Q0    = 2'd0,
        SEL_Q1    = 2'd1,
        SEL_BEND  = 2'd2,
        SEL_SLOPE = 2'd3
    } t_sel;

    t_state              r_state;
    logic [2:0]          r_degree;
    logic [6:0]          r_count;
    t_q                  r_t;
    logic [IW-1:0]       r_n;
    logic [PW-1:0]       r_p;
    logic [IW-1:0]       r_seg;
    logic [JW-1:0]       r_j;
    logic [PW-1:0]       r_k;
    logic [PW-1:0]       r_i;
    logic [1:0]          r_d;
    t_q                  r_kn [4];
    t_q                  r_lo;
    t_vec                r_w0;
    t_vec                r_w1;
    t_vec                r_w2;
    t_vec                r_nw;
    t_q                  r_alpha;
    t_q                  r_q0;
    t_q                  r_q1;
    t_vec                r_bend;
    t_vec                r_slope;
    logic                r_flag;
    logic                r_bdone;
    logic                r_sdone;
    logic                r_skip;
    t_sel                r_sel;
    t_out                r_out;
    logic                r_ovalid;

    // stores and their registered read data
    t_q                  knot_mem [KD];
    t_vec                point_mem [MAX_POINTS];
    t_vec                work_mem [WD];
    t_q                  r_kd;
    t_vec                r_pd;
    t_vec                r_wd0;
    t_vec                r_wd1;

    logic                in_acc;
    logic                knot_we;
    logic                pt_we;
    t_vec                pt_wdata;
    logic [IW-1:0]       kaddr_full;
    logic [IW-1:0]       paddr_full;
    logic [WAW-1:0]      wa0;
    logic [WAW-1:0]      wa1;
    logic                wp_we;
    logic [WAW-1:0]      wp_wa;
    t_vec                wp_wdata;
    logic signed [32:0]  span;
    logic signed [NUM_W-1:0] alpha_num;
    logic signed [32:0]  diff_d;
    logic signed [NUM_W-1:0] sc_num;
    logic signed [32:0]  sc_den;
    logic signed [32:0]  sc_diff;
    logic [PW-1:0]       sc_mult;
    logic signed [37+PW:0] sc_prod;
    logic signed [63:0]  interp_sum;
    t_q                  alpha_nx;
    logic [IW-1:0]       pc_ext;
    logic [IW-1:0]       dg_ext;
    logic [IW-1:0]       n_eval;
    logic [IW-1:0]       p_eval;
    t_mdu_req            mdu_req;
    t_mdu_rsp            mdu_rsp;

    // --------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd3;
            r_count  <= 7'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEGREE: r_degree <= i_cfg_wdata[2:0];
                CFG_COUNT:  r_count  <= i_cfg_wdata;
                default:    r_count  <= r_count;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // input beat decode
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign knot_we    = in_acc && (i_in_data.op == OP_KNOT)
                        && (IW'(i_in_data.slot) < IW'(KD));
    assign pt_we      = in_acc && (i_in_data.op == OP_POINT)
                        && (IW'(i_in_data.slot) < IW'(MAX_POINTS));

    always_comb begin
        pt_wdata[0] = i_in_data.coord_x;
        pt_wdata[1] = i_in_data.coord_y;
        pt_wdata[2] = (DIMENSION > 2) ? i_in_data.coord_z : 32'sd0;
    end

    // effective count and degree
    always_comb begin
        pc_ext = IW'(r_count);
        dg_ext = IW'(r_degree);
        if (pc_ext < IW'(2)) begin
            n_eval = IW'(2);
        end else if (pc_ext > IW'(MAX_POINTS)) begin
            n_eval = IW'(MAX_POINTS);
        end else begin
            n_eval = pc_ext;
        end
        if (dg_ext < IW'(1)) begin
            p_eval = IW'(1);
        end else if (dg_ext > IW'(MAX_DEGREE)) begin
            p_eval = IW'(MAX_DEGREE);
        end else begin
            p_eval = dg_ext;
        end
        if (p_eval > n_eval - IW'(1)) begin
            p_eval = n_eval - IW'(1);
        end
    end

    // --------------------------------------------------------------------
    // store addressing
    always_comb begin
        case (r_state)
            ST_SRCH: kaddr_full = r_seg + IW'(1);
            ST_KF:   kaddr_full = r_seg + IW'(r_j) - IW'(1);
            ST_ILD:  kaddr_full = r_seg + IW'(1) + IW'(r_k) + IW'(r_i) - IW'(r_p);
            ST_ILD2: kaddr_full = r_seg + IW'(1) + IW'(r_i);
            default: kaddr_full = '0;
        endcase
        paddr_full = r_seg + IW'(1) + IW'(r_j) - IW'(r_p);
        case (r_state)
            ST_ILD: begin
                wa0 = WAW'(r_i);
                wa1 = WAW'(r_i) + WAW'(1);
            end
            ST_BND2: begin
                wa0 = WAW'(2);
                wa1 = WAW'(1);
            end
            ST_BND, ST_SLP: begin
                wa0 = '0;
                wa1 = WAW'(1);
            end
            default: begin
                wa0 = '0;
                wa1 = '0;
            end
        endcase
        wp_we    = (r_state == ST_CPW) || (r_state == ST_IWB);
        wp_wa    = (r_state == ST_CPW) ? WAW'(r_j) : WAW'(r_i);
        wp_wdata = (r_state == ST_CPW) ? r_pd : r_nw;
    end

    // knot store
    always_ff @(posedge i_clk) begin
        if (knot_we) begin
            knot_mem[i_in_data.slot[KAW-1:0]] <= i_in_data.param_value;
        end
        r_kd <= knot_mem[kaddr_full[KAW-1:0]];
    end

    // control point store
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            point_mem[i_in_data.slot[PAW-1:0]] <= pt_wdata;
        end
        r_pd <= point_mem[paddr_full[PAW-1:0]];
    end

    // de Boor work points
    always_ff @(posedge i_clk) begin
        if (wp_we) begin
            work_mem[wp_wa] <= wp_wdata;
        end
        r_wd0 <= work_mem[wa0];
        r_wd1 <= work_mem[wa1];
    end

    // --------------------------------------------------------------------
    // datapath terms around the shared unit
    always_comb begin
        span      = $signed({r_kd[31], r_kd}) - $signed({r_lo[31], r_lo});
        alpha_num = NUM_W'($signed({r_t[31], r_t}) - $signed({r_lo[31], r_lo})) <<< 16;
        diff_d    = $signed({r_w1[r_d][31], r_w1[r_d]})
                    - $signed({r_w0[r_d][31], r_w0[r_d]});

        case (r_sel)
            SEL_Q0: begin
                sc_diff = diff_d;
                sc_mult = r_p - PW'(1);
                sc_den  = $signed({r_kn[2][31], r_kn[2]}) - $signed({r_kn[0][31], r_kn[0]});
            end
            SEL_Q1: begin
                sc_diff = $signed({r_w2[r_d][31], r_w2[r_d]})
                          - $signed({r_w1[r_d][31], r_w1[r_d]});
                sc_mult = r_p - PW'(1);
                sc_den  = $signed({r_kn[3][31], r_kn[3]}) - $signed({r_kn[1][31], r_kn[1]});
            end
            SEL_BEND: begin
                sc_diff = $signed({r_q1[31], r_q1}) - $signed({r_q0[31], r_q0});
                sc_mult = r_p;
                sc_den  = $signed({r_kn[2][31], r_kn[2]}) - $signed({r_kn[1][31], r_kn[1]});
            end
            default: begin
                sc_diff = diff_d;
                sc_mult = r_p;
                sc_den  = $signed({r_kn[2][31], r_kn[2]}) - $signed({r_kn[1][31], r_kn[1]});
            end
        endcase
        sc_prod = (38+PW)'(sc_diff) * $signed({1'b0, sc_mult});
        sc_num  = NUM_W'(sc_prod) <<< 16;

        // round the product back to Q16.16 and add to the lower point
        interp_sum = ((mdu_rsp.res + 64'sd32768) >>> 16) + 64'($signed(r_w0[r_d]));

        if (mdu_rsp.res > 64'sd1073741824) begin
            alpha_nx = 32'sd1073741824;
        end else if (mdu_rsp.res < -64'sd1073741824) begin
            alpha_nx = -32'sd1073741824;
        end else begin
            alpha_nx = mdu_rsp.res[31:0];
        end

        mdu_req.start = ((r_state == ST_ISPAN) && (span != 33'sd0))
                        || (r_state == ST_IMUL)
                        || ((r_state == ST_SC) && (sc_den != 33'sd0));
        mdu_req.op    = (r_state == ST_IMUL) ? MDU_MUL : MDU_DIV;
        case (r_state)
            ST_ISPAN: begin
                mdu_req.a = alpha_num;
                mdu_req.b = span;
            end
            ST_IMUL: begin
                mdu_req.a = NUM_W'(diff_d);
                mdu_req.b = DEN_W'(r_alpha);
            end
            default: begin
                mdu_req.a = sc_num;
                mdu_req.b = sc_den;
            end
        endcase
    end

    bsp_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .o_rsp   (mdu_rsp)
    );

    // --------------------------------------------------------------------
    // evaluation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_flag   <= 1'b0;
            r_bdone  <= 1'b0;
            r_sdone  <= 1'b0;
            r_skip   <= 1'b0;
        end else begin
            // result beat taken; the output state reloads it itself
            if (r_ovalid && i_out_ready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in_data.op == OP_EVAL)) begin
                        r_t     <= i_in_data.param_value;
                        r_n     <= n_eval;
                        r_p     <= PW'(p_eval);
                        r_seg   <= p_eval - IW'(1);
                        r_j     <= '0;
                        r_k     <= '0;
                        r_flag  <= 1'b0;
                        r_bdone <= 1'b0;
                        r_sdone <= 1'b0;
                        r_bend  <= '0;
                        r_slope <= '0;
                        r_state <= ST_SRCH;
                    end
                end
                // interval search, one knot at a time
                ST_SRCH: begin
                    r_state <= (r_seg + IW'(2) < r_n) ? ST_SRCHW : ST_KF;
                end
                ST_SRCHW: begin
                    if (r_kd <= r_t) begin
                        r_seg   <= r_seg + IW'(1);
                        r_state <= ST_SRCH;
                    end else begin
                        r_state <= ST_KF;
                    end
                end
                // fetch the four knots around the segment
                ST_KF: r_state <= ST_KFW;
                ST_KFW: begin
                    r_kn[r_j[1:0]] <= r_kd;
                    if (r_j == JW'(3)) begin
                        r_j     <= '0;
                        r_state <= ST_CP;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= ST_KF;
                    end
                end
                // copy the control points of the segment
                ST_CP: r_state <= ST_CPW;
                ST_CPW: begin
                    if (r_j == JW'(r_p)) begin
                        r_state <= ST_NEXT;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= ST_CP;
                    end
                end
                ST_NEXT: begin
                    r_i <= '0;
                    if ((r_p >= PW'(2)) && (({1'b0, r_k} + (PW+1)'(2)) == {1'b0, r_p})
                        && !r_bdone) begin
                        r_state <= ST_BND;
                    end else if ((({1'b0, r_k} + (PW+1)'(1)) == {1'b0, r_p}) && !r_sdone) begin
                        r_state <= ST_SLP;
                    end else if (r_k == r_p) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_ILD;
                    end
                end
                // one interpolation of a de Boor stage
                ST_ILD: r_state <= ST_ILD2;
                ST_ILD2: begin
                    r_lo    <= r_kd;
                    r_w0    <= r_wd0;
                    r_w1    <= r_wd1;
                    r_state <= ST_ISPAN;
                end
                ST_ISPAN: begin
                    if (span == 33'sd0) begin
                        r_flag <= 1'b1;
                        r_skip <= 1'b1;
                    end else begin
                        r_skip <= 1'b0;
                    end
                    r_state <= ST_IDIV;
                end
                ST_IDIV: begin
                    if (r_skip || mdu_rsp.done) begin
                        r_alpha <= r_skip ? 32'sd0 : alpha_nx;
                        r_d     <= '0;
                        r_state <= ST_IMUL;
                    end
                end
                ST_IMUL: r_state <= ST_IMULW;
                ST_IMULW: begin
                    if (mdu_rsp.done) begin
                        r_nw[r_d] <= sat32(interp_sum);
                        if (r_d == 2'd2) begin
                            r_state <= ST_IWB;
                        end else begin
                            r_d     <= r_d + 2'd1;
                            r_state <= ST_IMUL;
                        end
                    end
                end
                ST_IWB: begin
                    if (({1'b0, r_i} + (PW+1)'(1) + {1'b0, r_k}) == {1'b0, r_p}) begin
                        r_k     <= r_k + PW'(1);
                        r_state <= ST_NEXT;
                    end else begin
                        r_i     <= r_i + PW'(1);
                        r_state <= ST_ILD;
                    end
                end
                // second derivative from the three leading points
                ST_BND: r_state <= ST_BND2;
                ST_BND2: begin
                    r_w0    <= r_wd0;
                    r_w1    <= r_wd1;
                    r_state <= ST_BND3;
                end
                ST_BND3: begin
                    r_w2    <= r_wd0;
                    r_d     <= '0;
                    r_sel   <= SEL_Q0;
                    r_state <= ST_SC;
                end
                // first derivative from the two leading points
                ST_SLP: r_state <= ST_SLP2;
                ST_SLP2: begin
                    r_w0    <= r_wd0;
                    r_w1    <= r_wd1;
                    r_d     <= '0;
                    r_sel   <= SEL_SLOPE;
                    r_state <= ST_SC;
                end
                // scaled difference over a knot span
                ST_SC: begin
                    if (sc_den == 33'sd0) begin
                        r_flag <= 1'b1;
                        r_skip <= 1'b1;
                    end else begin
                        r_skip <= 1'b0;
                    end
                    r_state <= ST_SCW;
                end
                ST_SCW: begin
                    if (r_skip || mdu_rsp.done) begin
                        r_state <= ST_SC;
                        case (r_sel)
                            SEL_Q0: begin
                                r_q0  <= r_skip ? 32'sd0 : sat32(mdu_rsp.res);
                                r_sel <= SEL_Q1;
                            end
                            SEL_Q1: begin
                                r_q1  <= r_skip ? 32'sd0 : sat32(mdu_rsp.res);
                                r_sel <= SEL_BEND;
                            end
                            SEL_BEND: begin
                                r_bend[r_d] <= r_skip ? 32'sd0 : sat32(mdu_rsp.res);
                                r_sel       <= SEL_Q0;
                                if (r_d == 2'd2) begin
                                    r_bdone <= 1'b1;
                                    r_state <= ST_NEXT;
                                end else begin
                                    r_d <= r_d + 2'd1;
                                end
                            end
                            default: begin
                                r_slope[r_d] <= r_skip ? 32'sd0 : sat32(mdu_rsp.res);
                                if (r_d == 2'd2) begin
                                    r_sdone <= 1'b1;
                                    r_state <= ST_NEXT;
                                end else begin
                                    r_d <= r_d + 2'd1;
                                end
                            end
                        endcase
                    end
                end
                // read the final point and hand over the result beat
                ST_FIN: r_state <= ST_OUT;
                ST_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.point_x    <= r_wd0[0];
                        r_out.point_y    <= r_wd0[1];
                        r_out.point_z    <= r_wd0[2];
                        r_out.slope_x    <= r_slope[0];
                        r_out.slope_y    <= r_slope[1];
                        r_out.slope_z    <= r_slope[2];
                        r_out.bend_x     <= r_bend[0];
                        r_out.bend_y     <= r_bend[1];
                        r_out.bend_z     <= r_bend[2];
                        r_out.bend_valid <= (r_p >= PW'(2));
                        r_out.zero_span  <= r_flag;
                        r_ovalid         <= 1'b1;
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== verif/bspline_de_boor_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator_tb
// Drives knot writes, control point writes and curve evaluations through the
// valid/ready input channel and checks every result beat against a fixed
// point de Boor predictor kept inside the bench. Runs directed corner cases
// and then random traffic over several degree and point count settings,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module bspline_de_boor_evaluator_tb;
    import bsp_pkg::*;

    localparam int KNOT_SLOTS  = MAX_POINTS_DEF + MAX_DEGREE_DEF - 1;
    localparam longint Q_ONE   = 65536;
    localparam longint ALPHA_MAX = longint'(1) << 30;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [6:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;

    bspline_de_boor_evaluator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // shadow copy of the block state
    longint     knot_mem [KNOT_SLOTS];
    longint     pnt_mem  [MAX_POINTS_DEF][3];
    longint     deboor_work [MAX_DEGREE_DEF+1][3];
    logic [2:0] deg_reg;
    logic [6:0] cnt_reg;
    bit         span_flag;

    t_out       curve_queue [$];
    int         mismatch_count;
    int         send_idle;
    int         recv_idle;
    int         items_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // effective count and degree after clamping
    function automatic void eff_shape(output int n, output int p);
        n = cnt_reg;
        if (n < 2) n = 2;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        p = deg_reg;
        if (p < 1) p = 1;
        if (p > MAX_DEGREE_DEF) p = MAX_DEGREE_DEF;
        if (p > n - 1) p = n - 1;
    endfunction

    // trunc(diff * mult * 2^16 / den), saturated; zero divisor flags
    function automatic longint span_ratio(longint diff, longint mult, longint den);
        if (den == 0) begin
            span_flag = 1'b1;
            return 0;
        end
        return clip32((diff * mult * Q_ONE) / den);
    endfunction

    // one de Boor stage on the working points
    function automatic void blend_stage(longint u, int seg, int p, int k);
        longint lo, hi, span, alpha, diff;
        for (int i = 0; i < p - k; i++) begin
            lo = knot_mem[seg - p + 1 + k + i];
            hi = knot_mem[seg + 1 + i];
            span = hi - lo;
            alpha = 0;
            if (span == 0) begin
                span_flag = 1'b1;
            end else begin
                alpha = ((u - lo) * Q_ONE) / span;
                if (alpha > ALPHA_MAX) alpha = ALPHA_MAX;
                if (alpha < -ALPHA_MAX) alpha = -ALPHA_MAX;
            end
            for (int d = 0; d < 3; d++) begin
                diff = deboor_work[i+1][d] - deboor_work[i][d];
                deboor_work[i][d] = clip32(deboor_work[i][d] + ((diff * alpha + 32768) >>> 16));
            end
        end
    endfunction

    // apply one accepted beat to the shadow state; returns 1 with a curve result
    function automatic bit predict_curve(input t_in b, output t_out r);
        int n, p, seg;
        longint u, q0, q1;
        longint slope [3];
        longint bend [3];
        r = '0;
        u = longint'(b.param_value);
        if (b.op == OP_KNOT) begin
            if (b.slot < KNOT_SLOTS) knot_mem[b.slot] = u;
            return 1'b0;
        end
        if (b.op == OP_POINT) begin
            if (b.slot < MAX_POINTS_DEF) begin
                pnt_mem[b.slot][0] = longint'(b.coord_x);
                pnt_mem[b.slot][1] = longint'(b.coord_y);
                pnt_mem[b.slot][2] = (DIMENSION_DEF > 2) ? longint'(b.coord_z) : 0;
            end
            return 1'b0;
        end
        if (b.op != OP_EVAL) return 1'b0;

        eff_shape(n, p);
        span_flag = 1'b0;
        seg = p - 1;
        while (seg < n - 2 && knot_mem[seg+1] <= u) seg++;
        for (int k = 0; k <= p; k++)
            for (int d = 0; d < 3; d++)
                deboor_work[k][d] = pnt_mem[seg - p + 1 + k][d];
        for (int d = 0; d < 3; d++) begin
            slope[d] = 0;
            bend[d] = 0;
        end
        for (int k = 0; k < p - 2; k++) blend_stage(u, seg, p, k);
        if (p >= 2) begin
            for (int d = 0; d < 3; d++) begin
                q0 = span_ratio(deboor_work[1][d] - deboor_work[0][d], p - 1,
                                knot_mem[seg+1] - knot_mem[seg-1]);
                q1 = span_ratio(deboor_work[2][d] - deboor_work[1][d], p - 1,
                                knot_mem[seg+2] - knot_mem[seg]);
                bend[d] = span_ratio(q1 - q0, p, knot_mem[seg+1] - knot_mem[seg]);
            end
            blend_stage(u, seg, p, p - 2);
        end
        for (int d = 0; d < 3; d++)
            slope[d] = span_ratio(deboor_work[1][d] - deboor_work[0][d], p,
                                  knot_mem[seg+1] - knot_mem[seg]);
        blend_stage(u, seg, p, p - 1);

        r.point_x    = deboor_work[0][0][31:0];
        r.point_y    = deboor_work[0][1][31:0];
        r.point_z    = deboor_work[0][2][31:0];
        r.slope_x    = slope[0][31:0];
        r.slope_y    = slope[1][31:0];
        r.slope_z    = slope[2][31:0];
        r.bend_x     = bend[0][31:0];
        r.bend_y     = bend[1][31:0];
        r.bend_z     = bend[2][31:0];
        r.bend_valid = (p >= 2);
        r.zero_span  = span_flag;
        return 1'b1;
    endfunction

    // send one input beat and record what it should produce
    task automatic send_beat(input t_in b);
        t_out r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = b;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (predict_curve(b, r)) curve_queue.push_back(r);
    endtask

    task automatic send_op(input logic [1:0] op, input int slot, input longint v,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        t_in b;
        b.op = op;
        b.slot = 7'(slot);
        b.param_value = v[31:0];
        b.coord_x = x;
        b.coord_y = y;
        b.coord_z = z;
        send_beat(b);
    endtask

    task automatic eval_at(input longint u);
        send_op(OP_EVAL, $urandom_range(127), u, $urandom, $urandom, $urandom);
    endtask

    // wait until every result is in, then let the block settle
    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (curve_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [6:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        if (idx == CFG_DEGREE) deg_reg = val[2:0];
        else cnt_reg = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ascending knots with random steps, some repeated
    task automatic fill_knots(input int last);
        longint v;
        v = longint'($urandom_range(400000)) - 200000;
        for (int i = 0; i <= last; i++) begin
            send_op(OP_KNOT, i, v, $urandom, $urandom, $urandom);
            if ($urandom_range(9) != 0) v += $urandom_range(1, 3 * 65536);
        end
    endtask

    task automatic fill_points(input int last);
        for (int i = 0; i <= last; i++)
            send_op(OP_POINT, i, $urandom, $urandom_range(2000000) - 1000000,
                    $urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000);
    endtask

    function automatic longint rand_param(int last);
        longint lo, hi;
        lo = knot_mem[0] - Q_ONE;
        hi = knot_mem[last] + Q_ONE;
        if (hi <= lo) return lo;
        return lo + (longint'($urandom) % (hi - lo + 1));
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (curve_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %h", o_out_data);
            end else begin
                want = curve_queue.pop_front();
                if (o_out_data.point_x !== want.point_x || o_out_data.point_y !== want.point_y ||
                    o_out_data.point_z !== want.point_z || o_out_data.slope_x !== want.slope_x ||
                    o_out_data.slope_y !== want.slope_y || o_out_data.slope_z !== want.slope_z ||
                    o_out_data.bend_x !== want.bend_x || o_out_data.bend_y !== want.bend_y ||
                    o_out_data.bend_z !== want.bend_z ||
                    o_out_data.bend_valid !== want.bend_valid ||
                    o_out_data.zero_span !== want.zero_span) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h actual %h", want, o_out_data);
                end
            end
        end
    end

    // receiver readiness
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // every store entry gets a value before anything reads it
    task automatic test_fill_stores;
        fill_knots(KNOT_SLOTS - 1);
        fill_points(MAX_POINTS_DEF - 1);
    endtask

    // corner cases at the reset shape (degree 3, four points)
    task automatic test_directed;
        longint keep;
        eval_at(knot_mem[3]);
        eval_at((knot_mem[3] + knot_mem[4]) / 2);
        eval_at(knot_mem[0] - 5 * Q_ONE);
        eval_at(knot_mem[5] + 5 * Q_ONE);
        eval_at(-64'sd2147483648);
        eval_at(64'sd2147483647);
        // extreme coordinates
        send_op(OP_POINT, 1, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_op(OP_POINT, 2, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        eval_at(knot_mem[3]);
        // highest slots and ignored writes
        send_op(OP_KNOT, KNOT_SLOTS - 1, knot_mem[KNOT_SLOTS - 1], 0, 0, 0);
        send_op(OP_POINT, MAX_POINTS_DEF - 1, 0, 32'h12345678, 32'hFEDCBA98, 32'h0);
        send_op(OP_KNOT, KNOT_SLOTS, 0, 0, 0, 0);
        send_op(OP_KNOT, 127, -64'sd2147483648, 0, 0, 0);
        send_op(OP_POINT, MAX_POINTS_DEF, 0, 0, 0, 0);
        send_op(OP_POINT, 127, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_op(OP_UNUSED, 0, 0, 0, 0, 0);
        // zero knot span inside the active segment
        keep = knot_mem[4];
        send_op(OP_KNOT, 4, knot_mem[3], 0, 0, 0);
        eval_at(knot_mem[3]);
        send_op(OP_KNOT, 4, keep, 0, 0, 0);
        // extreme knot values
        send_op(OP_KNOT, 5, 64'sd2147483647, 0, 0, 0);
        send_op(OP_KNOT, 0, -64'sd2147483648, 0, 0, 0);
        eval_at(knot_mem[3] + 1);
        drain();
    endtask

    // random traffic under one shape
    task automatic test_random_shape(input logic [6:0] deg, input logic [6:0] cnt,
                                     input int items);
        int n, p, last, pick, first;
        write_cfg(CFG_DEGREE, deg);
        write_cfg(CFG_COUNT, cnt);
        eff_shape(n, p);
        last = n + p - 2;
        fill_knots(last);
        fill_points(n - 1);
        first = items_sent;
        while (items_sent - first < items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                eval_at(rand_param(last));
            end else if (pick < 70) begin
                fill_points($urandom_range(n - 1));
            end else if (pick < 80) begin
                // copy one knot value into a random slot, then refill every knot
                send_op(OP_KNOT, $urandom_range(last), knot_mem[$urandom_range(last)],
                        0, 0, 0);
                fill_knots(last);
            end else if (pick < 88) begin
                send_op(OP_POINT, $urandom_range(n - 1), 0, $urandom, $urandom, $urandom);
            end else if (pick < 94) begin
                eval_at(longint'($signed($urandom)));
            end else begin
                send_op($urandom_range(1) ? OP_UNUSED : OP_KNOT,
                        $urandom_range(KNOT_SLOTS, 127), $urandom, $urandom, $urandom, $urandom);
            end
        end
        drain();
    endtask

    task automatic test_shape_sweep;
        send_idle = 27;
        recv_idle = 59;
        test_random_shape(7'd3, 7'd4, 100);
        test_random_shape(7'd1, 7'd2, 80);
        test_random_shape(7'd7, 7'd64, 60);
        send_idle = 59;
        recv_idle = 27;
        test_random_shape(7'd2, 7'd10, 100);
        test_random_shape(7'd0, 7'd1, 60);
        test_random_shape(7'd7, 7'd127, 50);
        send_idle = 0;
        recv_idle = 0;
        test_random_shape(7'd5, 7'd6, 120);
        test_random_shape(7'd7, 7'd5, 120);
    endtask

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_DEGREE;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        deg_reg        = 3'd3;
        cnt_reg        = 7'd4;
        mismatch_count = 0;
        items_sent     = 0;
        send_idle      = 27;
        recv_idle      = 59;
        for (int i = 0; i < KNOT_SLOTS; i++) knot_mem[i] = 0;
        for (int i = 0; i < MAX_POINTS_DEF; i++)
            for (int d = 0; d < 3; d++) pnt_mem[i][d] = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fill_stores();
        test_directed();
        test_shape_sweep();

        if (mismatch_count == 0 && curve_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
